// ----- hdl/tcc_pkg.sv -----
// Shared constants and types for the terminal cursor control block.
// Depends on nothing; terminal_cursor_control uses it by scoped names.
package tcc_pkg;

  // Screen geometry. The port widths below are fixed for this geometry.
  localparam int COLUMNS = 80;
  localparam int ROWS    = 24;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

  // Parameter forms delivered by the parser front end.
  localparam logic [1:0] FORM_ONE     = 2'd0;
  localparam logic [1:0] FORM_TWO     = 2'd1;
  localparam logic [1:0] FORM_PRIVATE = 2'd2;

  // Final characters of the supported sequences.
  localparam logic [7:0] FIN_CUP      = 8'h48;  // 'H'
  localparam logic [7:0] FIN_HVP      = 8'h66;  // 'f'
  localparam logic [7:0] FIN_STBM     = 8'h72;  // 'r'
  localparam logic [7:0] FIN_UP       = 8'h41;  // 'A'
  localparam logic [7:0] FIN_DOWN     = 8'h42;  // 'B'
  localparam logic [7:0] FIN_FWD      = 8'h43;  // 'C'
  localparam logic [7:0] FIN_BACK     = 8'h44;  // 'D'
  localparam logic [7:0] FIN_ED       = 8'h4A;  // 'J'
  localparam logic [7:0] FIN_EL       = 8'h4B;  // 'K'
  localparam logic [7:0] FIN_SET      = 8'h68;  // 'h'
  localparam logic [7:0] FIN_RESET    = 8'h6C;  // 'l'

  // Private mode numbers.
  localparam logic [7:0] MODE_APP_CURSOR = 8'd1;
  localparam logic [7:0] MODE_CLEAR      = 8'd3;
  localparam logic [7:0] MODE_REVERSE    = 8'd5;
  localparam logic [7:0] MODE_ORIGIN     = 8'd6;
  localparam logic [7:0] MODE_AUTOWRAP   = 8'd7;

  // Erase selectors for J and K.
  localparam logic [7:0] ERASE_TO_END   = 8'd0;
  localparam logic [7:0] ERASE_TO_START = 8'd1;
  localparam logic [7:0] ERASE_ALL      = 8'd2;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_CLEAR   = 2'd1,
    ACT_SCROLL  = 2'd2,
    ACT_REVERSE = 2'd3
  } action_e;

  // One frame-buffer command.
  typedef struct packed {
    action_e          action;
    logic [ROW_W-1:0] row_first;
    logic [ROW_W-1:0] row_last;
    logic [COL_W-1:0] col_first;
    logic [COL_W-1:0] col_last;
  } cmd_t;

  // One complete result item as held in the output queue.
  typedef struct packed {
    logic [COL_W-1:0] cursor_col;
    logic [ROW_W-1:0] cursor_row;
    cmd_t             cmd;
    logic             app_cursor_mode;
    logic             autowrap_on;
    logic             reverse_video;
    logic             last_of_run;
  } result_t;

  // Output queue geometry: room for two worst-case sequences of two results each.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage

// ----- hdl/terminal_cursor_control.sv -----
// VT100 cursor, scroll-region and erase control, one sequence per transfer.
// Depends on tcc_pkg for geometry, codes, the command type and the queue size.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+--------------------------------
//   in      | input     | in_valid_i / in_ready_o   | final_code, params, form
//   out     | output    | out_valid_o / out_ready_i | cursor, action, rectangle, flags
//
// An accepted sequence is executed in the cycle of its transfer: the cursor,
// region and mode registers update at that edge and its one or two results
// enter a four-entry output queue. The first result is offered on the output
// from the next cycle on. One sequence can be taken every cycle while the input
// is ready; a sequence with two results (a split erase) fills two queue entries,
// so the output port's one-result-per-cycle drain, which out_ready_i can hold,
// sets the long-run rate for those. The input is ready whenever the queue has
// two free entries, so it stalls only while three or four results are waiting.
// Reset (rst_ni low, asynchronous) homes the cursor, sets the region to the full
// screen, clears all modes and empties the queue.
module terminal_cursor_control (
  input  logic       clk_i,
  input  logic       rst_ni,

  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] final_code_i,
  input  logic [7:0] first_param_i,
  input  logic [7:0] second_param_i,
  input  logic [1:0] param_form_i,

  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [6:0] cursor_col_o,
  output logic [4:0] cursor_row_o,
  output logic [1:0] action_o,
  output logic [4:0] row_first_o,
  output logic [4:0] row_last_o,
  output logic [6:0] col_first_o,
  output logic [6:0] col_last_o,
  output logic       app_cursor_mode_o,
  output logic       autowrap_on_o,
  output logic       reverse_video_o,
  output logic       last_of_run_o
);

  localparam logic [8:0] COLUMNS_9 = 9'(tcc_pkg::COLUMNS);
  localparam logic [8:0] ROWS_9    = 9'(tcc_pkg::ROWS);
  localparam logic [8:0] COL_MAX_9 = 9'(tcc_pkg::COLUMNS - 1);
  localparam logic [8:0] ROW_MAX_9 = 9'(tcc_pkg::ROWS - 1);

  // ---------------------------------------------------------------------
  // Terminal state.
  // ---------------------------------------------------------------------
  logic [tcc_pkg::COL_W-1:0] cur_col_q, cur_col_d;
  logic [tcc_pkg::ROW_W-1:0] cur_row_q, cur_row_d;
  logic [tcc_pkg::ROW_W-1:0] origin_row_q, origin_row_d;
  logic [tcc_pkg::ROW_W-1:0] region_top_q, region_top_d;
  logic [tcc_pkg::ROW_W-1:0] region_bottom_q, region_bottom_d;
  logic                      rel_origin_q, rel_origin_d;
  logic                      wrap_q, wrap_d;
  logic                      app_cursor_q, app_cursor_d;
  logic                      reverse_q, reverse_d;

  // Commands produced by the current sequence.
  tcc_pkg::cmd_t cmd0, cmd1;
  logic          two_cmds;

  logic in_fire;
  logic out_fire;

  // Scratch values for the sequence decode.
  logic [7:0] count_n;
  logic [7:0] p2_eff;
  logic [8:0] pos_col;
  logic [8:0] pos_row;
  logic [8:0] sum9;
  logic [7:0] top8;
  logic [7:0] bot8;
  logic       mode_set;

  tcc_pkg::cmd_t cmd_none;
  tcc_pkg::cmd_t cmd_line_to_end;

  // ---------------------------------------------------------------------
  // Sequence execution: clamps and compares on the current state.
  // ---------------------------------------------------------------------
  always_comb begin
    cmd_none        = '{action: tcc_pkg::ACT_NONE, default: '0};
    cmd_line_to_end = '{action: tcc_pkg::ACT_CLEAR, row_first: cur_row_q,
                        row_last: cur_row_q, col_first: cur_col_q,
                        col_last: tcc_pkg::COL_LAST};

    cur_col_d       = cur_col_q;
    cur_row_d       = cur_row_q;
    origin_row_d    = origin_row_q;
    region_top_d    = region_top_q;
    region_bottom_d = region_bottom_q;
    rel_origin_d    = rel_origin_q;
    wrap_d          = wrap_q;
    app_cursor_d    = app_cursor_q;
    reverse_d       = reverse_q;

    cmd0     = cmd_none;
    cmd1     = cmd_none;
    two_cmds = 1'b0;

    // A zero or absent count means one.
    count_n  = (first_param_i == 8'd0) ? 8'd1 : first_param_i;
    // In the one-parameter form the second number is taken as absent.
    p2_eff   = (param_form_i == tcc_pkg::FORM_TWO) ? second_param_i : 8'd0;
    mode_set = (final_code_i == tcc_pkg::FIN_SET);

    pos_col = (p2_eff == 8'd0) ? 9'd0 : ({1'b0, p2_eff} - 9'd1);
    pos_row = ((first_param_i == 8'd0) ? 9'd0 : ({1'b0, first_param_i} - 9'd1))
              + {4'd0, origin_row_q};
    sum9    = 9'd0;
    top8    = (first_param_i == 8'd0) ? 8'd0 : (first_param_i - 8'd1);
    bot8    = (p2_eff == 8'd0) ? 8'(tcc_pkg::ROWS - 1) : (p2_eff - 8'd1);

    if (param_form_i == tcc_pkg::FORM_PRIVATE) begin
      if ((final_code_i == tcc_pkg::FIN_SET) || (final_code_i == tcc_pkg::FIN_RESET)) begin
        case (first_param_i)
          tcc_pkg::MODE_APP_CURSOR: begin
            app_cursor_d = mode_set;
          end
          tcc_pkg::MODE_CLEAR: begin
            cmd0 = '{action: tcc_pkg::ACT_CLEAR, row_first: '0,
                     row_last: tcc_pkg::ROW_LAST, col_first: '0,
                     col_last: tcc_pkg::COL_LAST};
          end
          tcc_pkg::MODE_REVERSE: begin
            // The frame buffer is told only when the flag actually flips.
            if (reverse_q != mode_set) begin
              reverse_d = mode_set;
              cmd0      = '{action: tcc_pkg::ACT_REVERSE, default: '0};
            end
          end
          tcc_pkg::MODE_ORIGIN: begin
            rel_origin_d = mode_set;
            origin_row_d = mode_set ? region_top_q : '0;
            cur_col_d    = '0;
            cur_row_d    = mode_set ? region_top_q : '0;
          end
          tcc_pkg::MODE_AUTOWRAP: begin
            wrap_d = mode_set;
          end
          default: begin
          end
        endcase
      end
    end else if ((param_form_i == tcc_pkg::FORM_ONE) ||
                 (param_form_i == tcc_pkg::FORM_TWO)) begin
      case (final_code_i)
        tcc_pkg::FIN_CUP, tcc_pkg::FIN_HVP: begin
          // Past the right edge: wrap to the next row or pin to the edge.
          if (pos_col >= COLUMNS_9) begin
            if (wrap_q) begin
              pos_col = 9'd0;
              pos_row = pos_row + 9'd1;
            end else begin
              pos_col = COL_MAX_9;
            end
          end
          // Past the bottom: the region scrolls under autowrap, and the
          // row pins to the last one either way.
          if (pos_row >= ROWS_9) begin
            if (wrap_q) begin
              cmd0 = '{action: tcc_pkg::ACT_SCROLL, row_first: region_top_q,
                       row_last: region_bottom_q, col_first: '0,
                       col_last: tcc_pkg::COL_LAST};
            end
            pos_row = ROW_MAX_9;
          end
          cur_col_d = pos_col[tcc_pkg::COL_W-1:0];
          cur_row_d = pos_row[tcc_pkg::ROW_W-1:0];
        end
        tcc_pkg::FIN_STBM: begin
          if (top8 > 8'(tcc_pkg::ROWS - 1)) top8 = 8'(tcc_pkg::ROWS - 1);
          if (bot8 > 8'(tcc_pkg::ROWS - 1)) bot8 = 8'(tcc_pkg::ROWS - 1);
          // A region of one row, or one that is upside down, is ignored.
          if (top8 < bot8) begin
            region_top_d    = top8[tcc_pkg::ROW_W-1:0];
            region_bottom_d = bot8[tcc_pkg::ROW_W-1:0];
            if (rel_origin_q) begin
              origin_row_d = top8[tcc_pkg::ROW_W-1:0];
            end
            cur_col_d = '0;
            cur_row_d = rel_origin_q ? top8[tcc_pkg::ROW_W-1:0] : origin_row_q;
          end
        end
        tcc_pkg::FIN_UP: begin
          cur_row_d = ({3'd0, cur_row_q} > count_n)
                      ? (cur_row_q - count_n[tcc_pkg::ROW_W-1:0]) : '0;
        end
        tcc_pkg::FIN_DOWN: begin
          sum9      = {4'd0, cur_row_q} + {1'b0, count_n};
          cur_row_d = (sum9 > ROW_MAX_9) ? tcc_pkg::ROW_LAST
                                         : sum9[tcc_pkg::ROW_W-1:0];
        end
        tcc_pkg::FIN_FWD: begin
          sum9      = {2'd0, cur_col_q} + {1'b0, count_n};
          cur_col_d = (sum9 > COL_MAX_9) ? tcc_pkg::COL_LAST
                                         : sum9[tcc_pkg::COL_W-1:0];
        end
        tcc_pkg::FIN_BACK: begin
          cur_col_d = ({1'b0, cur_col_q} > count_n)
                      ? (cur_col_q - count_n[tcc_pkg::COL_W-1:0]) : '0;
        end
        tcc_pkg::FIN_ED: begin
          // The part of the screen on either side of the cursor is a
          // partial line plus a block of whole lines, hence two rectangles.
          case (first_param_i)
            tcc_pkg::ERASE_TO_END: begin
              cmd0 = cmd_line_to_end;
              if (cur_row_q < tcc_pkg::ROW_LAST) begin
                cmd1 = '{action: tcc_pkg::ACT_CLEAR,
                         row_first: cur_row_q + tcc_pkg::ROW_W'(1),
                         row_last: tcc_pkg::ROW_LAST, col_first: '0,
                         col_last: tcc_pkg::COL_LAST};
                two_cmds = 1'b1;
              end
            end
            tcc_pkg::ERASE_TO_START: begin
              if (cur_row_q != '0) begin
                cmd0 = '{action: tcc_pkg::ACT_CLEAR, row_first: '0,
                         row_last: cur_row_q - tcc_pkg::ROW_W'(1), col_first: '0,
                         col_last: tcc_pkg::COL_LAST};
                cmd1 = '{action: tcc_pkg::ACT_CLEAR, row_first: cur_row_q,
                         row_last: cur_row_q, col_first: '0,
                         col_last: cur_col_q};
                two_cmds = 1'b1;
              end else begin
                cmd0 = '{action: tcc_pkg::ACT_CLEAR, row_first: cur_row_q,
                         row_last: cur_row_q, col_first: '0,
                         col_last: cur_col_q};
              end
            end
            tcc_pkg::ERASE_ALL: begin
              cmd0 = '{action: tcc_pkg::ACT_CLEAR, row_first: '0,
                       row_last: tcc_pkg::ROW_LAST, col_first: '0,
                       col_last: tcc_pkg::COL_LAST};
            end
            default: begin
            end
          endcase
        end
        tcc_pkg::FIN_EL: begin
          case (first_param_i)
            tcc_pkg::ERASE_TO_END: begin
              cmd0 = cmd_line_to_end;
            end
            tcc_pkg::ERASE_TO_START: begin
              cmd0 = '{action: tcc_pkg::ACT_CLEAR, row_first: cur_row_q,
                       row_last: cur_row_q, col_first: '0, col_last: cur_col_q};
            end
            tcc_pkg::ERASE_ALL: begin
              cmd0 = '{action: tcc_pkg::ACT_CLEAR, row_first: cur_row_q,
                       row_last: cur_row_q, col_first: '0,
                       col_last: tcc_pkg::COL_LAST};
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // State registers: updated at the edge of each input transfer.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q       <= '0;
      cur_row_q       <= '0;
      origin_row_q    <= '0;
      region_top_q    <= '0;
      region_bottom_q <= tcc_pkg::ROW_LAST;
      rel_origin_q    <= 1'b0;
      wrap_q          <= 1'b0;
      app_cursor_q    <= 1'b0;
      reverse_q       <= 1'b0;
    end else if (in_fire) begin
      cur_col_q       <= cur_col_d;
      cur_row_q       <= cur_row_d;
      origin_row_q    <= origin_row_d;
      region_top_q    <= region_top_d;
      region_bottom_q <= region_bottom_d;
      rel_origin_q    <= rel_origin_d;
      wrap_q          <= wrap_d;
      app_cursor_q    <= app_cursor_d;
      reverse_q       <= reverse_d;
    end
  end

  // ---------------------------------------------------------------------
  // Output queue. Both results of a sequence carry the state after it.
  // ---------------------------------------------------------------------
  tcc_pkg::result_t res0, res1;

  always_comb begin
    res0 = '{cursor_col: cur_col_d, cursor_row: cur_row_d, cmd: cmd0,
             app_cursor_mode: app_cursor_d, autowrap_on: wrap_d,
             reverse_video: reverse_d, last_of_run: !two_cmds};
    res1 = '{cursor_col: cur_col_d, cursor_row: cur_row_d, cmd: cmd1,
             app_cursor_mode: app_cursor_d, autowrap_on: wrap_d,
             reverse_video: reverse_d, last_of_run: 1'b1};
  end

  tcc_pkg::result_t          queue_q [tcc_pkg::QUEUE_DEPTH];
  logic [tcc_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [tcc_pkg::QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [tcc_pkg::QCNT_W-1:0] fill_q, fill_d;
  logic [tcc_pkg::QCNT_W-1:0] push_cnt;

  // Ready while two entries are free, so the worst-case sequence always fits.
  assign in_ready_o  = (fill_q <= tcc_pkg::QCNT_W'(tcc_pkg::QUEUE_DEPTH - 2));
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = (fill_q != '0);
  assign out_fire    = out_valid_o && out_ready_i;

  always_comb begin
    push_cnt = in_fire ? (two_cmds ? tcc_pkg::QCNT_W'(2) : tcc_pkg::QCNT_W'(1)) : '0;
    fill_d   = fill_q + push_cnt - tcc_pkg::QCNT_W'(out_fire);
    wr_ptr_d = wr_ptr_q + push_cnt[tcc_pkg::QPTR_W-1:0];
    rd_ptr_d = rd_ptr_q + tcc_pkg::QPTR_W'(out_fire);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      queue_q[wr_ptr_q] <= res0;
      if (two_cmds) begin
        queue_q[wr_ptr_q + tcc_pkg::QPTR_W'(1)] <= res1;
      end
    end
  end

  tcc_pkg::result_t head;
  assign head = queue_q[rd_ptr_q];

  assign cursor_col_o      = head.cursor_col;
  assign cursor_row_o      = head.cursor_row;
  assign action_o          = head.cmd.action;
  assign row_first_o       = head.cmd.row_first;
  assign row_last_o        = head.cmd.row_last;
  assign col_first_o       = head.cmd.col_first;
  assign col_last_o        = head.cmd.col_last;
  assign app_cursor_mode_o = head.app_cursor_mode;
  assign autowrap_on_o     = head.autowrap_on;
  assign reverse_video_o   = head.reverse_video;
  assign last_of_run_o     = head.last_of_run;

endmodule
